>>> rtl/sepq_pkg.sv
`timescale 1ns / 1ps
package sepq_pkg;

  // Operation codes carried on the mode input
  localparam logic [2:0] MODE_INSERT     = 3'd0;
  localparam logic [2:0] MODE_PEEK       = 3'd1;
  localparam logic [2:0] MODE_POP        = 3'd2;
  localparam logic [2:0] MODE_FIND       = 3'd3;
  localparam logic [2:0] MODE_DEL_FIRST  = 3'd4;
  localparam logic [2:0] MODE_DEL_ALL    = 3'd5;
  localparam logic [2:0] MODE_DEL_ENTRY  = 3'd6;
  localparam logic [2:0] MODE_CLEAR      = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // Configuration register indexes
  localparam logic REG_ALLOW_DUP = 1'b0;
  localparam logic REG_APPEND    = 1'b1;

  localparam int OUT_CNT_BITS = 7;

endpackage

>>> rtl/sorted_event_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted event priority queue. Holds up to DEPTH (key, tag) entries in one
// synchronous memory in ascending unsigned key order. A command is taken when
// start is high and busy is low; exactly one result follows, shown for a
// single cycle with done high, and the receiver cannot stall it. Each entry
// touched is read through the single registered read port of the entry
// memory and then checked or written back in a separate state: a key search
// reads entries from the head up to the first larger key, then an insert
// moves every later entry up and a delete moves every later entry down.
// Clear, and peek or pop on an empty store, answer straight from the idle
// state without reading the memory; a search on an empty store skips the scan.
module sorted_event_priority_queue_top #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           mode,
  input  logic [KEY_BITS-1:0]                  key,
  input  logic [TAG_BITS-1:0]                  tag,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [KEY_BITS-1:0]                  out_key,
  output logic [TAG_BITS-1:0]                  out_tag,
  output logic [sepq_pkg::OUT_CNT_BITS-1:0]    removed_count,
  output logic [sepq_pkg::OUT_CNT_BITS-1:0]    occupancy,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic                                 cfg_data
);
  import sepq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + TAG_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_HEAD_RD, S_HEAD_CHK,
    S_UP_RD, S_UP_WR, S_INS_WR, S_DN_RD, S_DN_WR
  } state_t;

  state_t          state;
  logic [EW-1:0]   entry_mem [DEPTH];
  logic [EW-1:0]   rd_data;
  logic            wr_en;
  logic [CW-1:0]   wr_pos;
  logic [EW-1:0]   wr_data;

  logic            allow_dup;
  logic            append_eq;
  logic [2:0]      op;
  logic [KEY_BITS-1:0] op_key;
  logic [TAG_BITS-1:0] op_tag;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  logic [CW-1:0]   tpos;
  logic [CW-1:0]   gap;
  logic            seen_eq;
  logic            tag_found;
  logic [1:0]      res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CW-1:0]   res_removed;

  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic            key_eq;
  logic            key_gt;
  logic [CW-1:0]   ins_sel;

  assign rd_key  = rd_data[EW-1:TAG_BITS];
  assign rd_tag  = rd_data[TAG_BITS-1:0];
  assign key_eq  = (rd_key == op_key);
  assign key_gt  = (rd_key > op_key);
  assign ins_sel = append_eq ? hi : lo;

  assign busy          = (state != S_IDLE);
  assign status        = res_status;
  assign out_key       = res_key;
  assign out_tag       = res_tag;
  assign removed_count = OUT_CNT_BITS'(res_removed);
  assign occupancy     = OUT_CNT_BITS'(count);

  // Select the write for the shifting states
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = idx;
    wr_data = rd_data;
    unique case (state)
      S_UP_WR: begin
        wr_en  = 1'b1;
        wr_pos = idx + ONE_C;
      end
      S_DN_WR: begin
        wr_en  = 1'b1;
        wr_pos = idx - gap;
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_pos  = tpos;
        wr_data = {op_key, op_tag};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_pos[AW-1:0]] <= wr_data;
    end
    rd_data <= entry_mem[idx[AW-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_dup <= 1'b1;
      append_eq <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_ALLOW_DUP) begin
        allow_dup <= cfg_data;
      end else if (cfg_index == REG_APPEND) begin
        append_eq <= cfg_data;
      end
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op          <= mode;
            op_key      <= key;
            op_tag      <= tag;
            idx         <= '0;
            seen_eq     <= 1'b0;
            tag_found   <= 1'b0;
            res_status  <= ST_OK;
            res_key     <= '0;
            res_tag     <= '0;
            res_removed <= '0;
            unique case (mode)
              MODE_CLEAR: begin
                res_removed <= count;
                count       <= '0;
                done        <= 1'b1;
              end
              MODE_PEEK, MODE_POP: begin
                if (count == '0) begin
                  res_status <= ST_MISS;
                  done       <= 1'b1;
                end else begin
                  state <= S_HEAD_RD;
                end
              end
              MODE_INSERT, MODE_FIND, MODE_DEL_FIRST, MODE_DEL_ALL,
              MODE_DEL_ENTRY: begin
                if (count == '0) begin
                  lo    <= '0;
                  hi    <= '0;
                  state <= S_DECIDE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        // Walk the sorted entries until the first key above the command key
        S_SCAN_CHK: begin
          if (key_eq) begin
            if (!seen_eq) begin
              lo      <= idx;
              seen_eq <= 1'b1;
            end
            if (rd_tag == op_tag && !tag_found) begin
              tpos      <= idx;
              tag_found <= 1'b1;
            end
          end
          if (key_gt) begin
            hi <= idx;
            if (!seen_eq) lo <= idx;
            state <= S_DECIDE;
          end else if (idx == count - ONE_C) begin
            hi <= count;
            if (!seen_eq && !key_eq) lo <= count;
            state <= S_DECIDE;
          end else begin
            idx   <= idx + ONE_C;
            state <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          priority case (op)
            MODE_INSERT: begin
              if (!allow_dup && seen_eq) begin
                res_status <= ST_DUP;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if (count >= DEPTH_C) begin
                res_status <= ST_FULL;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                tpos <= ins_sel;
                if (ins_sel < count) begin
                  idx   <= count - ONE_C;
                  state <= S_UP_RD;
                end else begin
                  state <= S_INS_WR;
                end
              end
            end
            MODE_FIND: begin
              if (seen_eq) begin
                idx   <= lo;
                state <= S_HEAD_RD;
              end else begin
                res_status <= ST_MISS;
                done       <= 1'b1;
                state      <= S_IDLE;
              end
            end
            default: begin
              // Remove a run [first, first + gap) and close the hole
              if ((op == MODE_DEL_ENTRY) ? tag_found : seen_eq) begin
                if (op == MODE_DEL_ENTRY) begin
                  gap         <= ONE_C;
                  res_removed <= ONE_C;
                  idx         <= tpos + ONE_C;
                  if (tpos + ONE_C < count) begin
                    state <= S_DN_RD;
                  end else begin
                    count <= count - ONE_C;
                    done  <= 1'b1;
                    state <= S_IDLE;
                  end
                end else if (op == MODE_DEL_ALL) begin
                  gap         <= hi - lo;
                  res_removed <= hi - lo;
                  idx         <= hi;
                  if (hi < count) begin
                    state <= S_DN_RD;
                  end else begin
                    count <= count - (hi - lo);
                    done  <= 1'b1;
                    state <= S_IDLE;
                  end
                end else begin
                  gap         <= ONE_C;
                  res_removed <= ONE_C;
                  idx         <= lo + ONE_C;
                  if (lo + ONE_C < count) begin
                    state <= S_DN_RD;
                  end else begin
                    count <= count - ONE_C;
                    done  <= 1'b1;
                    state <= S_IDLE;
                  end
                end
              end else begin
                res_status <= ST_MISS;
                done       <= 1'b1;
                state      <= S_IDLE;
              end
            end
          endcase
        end
        S_HEAD_RD: begin
          state <= S_HEAD_CHK;
        end
        // Report the entry read; pop also drops the head
        S_HEAD_CHK: begin
          res_key <= rd_key;
          res_tag <= rd_tag;
          if (op == MODE_POP) begin
            gap         <= ONE_C;
            res_removed <= ONE_C;
            idx         <= ONE_C;
            if (ONE_C < count) begin
              state <= S_DN_RD;
            end else begin
              count <= count - ONE_C;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        // Move one entry up, walking down to the insert point
        S_UP_WR: begin
          if (idx == tpos) begin
            state <= S_INS_WR;
          end else begin
            idx   <= idx - ONE_C;
            state <= S_UP_RD;
          end
        end
        S_INS_WR: begin
          count <= count + ONE_C;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_DN_RD: begin
          state <= S_DN_WR;
        end
        // Move one entry down over the removed run
        S_DN_WR: begin
          if (idx == count - ONE_C) begin
            count <= count - gap;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + ONE_C;
            state <= S_DN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(count))
    else $error("entry count changed without a transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (out_key == '0 && out_tag == '0))
    else $error("entry fields set on failed transaction");

endmodule
